>>> rtl/core/skd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skd_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] scan_byte;
  } skd_item_t;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [6:0] ascii_char;
    logic       line_locked;
    logic       shift_held;
    logic       caps_active;
  } skd_result_t;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_CHAR      = 4'd1,
    EV_BACKSPACE = 4'd2,
    EV_ENTER     = 4'd3,
    EV_DELETE    = 4'd4,
    EV_LEFT      = 4'd5,
    EV_RIGHT     = 4'd6,
    EV_HOME      = 4'd7,
    EV_END       = 4'd8,
    EV_UP        = 4'd9,
    EV_DOWN      = 4'd10
  } skd_event_t;

  // command codes
  localparam logic CMD_SCAN       = 1'b0;
  localparam logic CMD_LINE_TAKEN = 1'b1;

  // scancodes
  localparam logic [7:0] SC_PREFIX      = 8'hE0;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_CAPS        = 8'h3A;
  localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
  localparam logic [7:0] SC_ENTER       = 8'h1C;
  localparam logic [7:0] SC_CODE_LIMIT  = 8'd57;
  localparam logic [7:0] SC_EXT_UP      = 8'h48;
  localparam logic [7:0] SC_EXT_DOWN    = 8'h50;
  localparam logic [7:0] SC_EXT_LEFT    = 8'h4B;
  localparam logic [7:0] SC_EXT_RIGHT   = 8'h4D;
  localparam logic [7:0] SC_EXT_DELETE  = 8'h53;
  localparam logic [7:0] SC_EXT_HOME    = 8'h47;
  localparam logic [7:0] SC_EXT_END     = 8'h4F;

  localparam logic [6:0] CASE_OFFSET = 7'd32;

  // unshifted key table, 0 marks a key with no character
  function automatic logic [6:0] plain_char(input logic [5:0] code);
    logic [6:0] c;
    case (code)
      6'd2:  c = 7'h31;  6'd3:  c = 7'h32;  6'd4:  c = 7'h33;  6'd5:  c = 7'h34;
      6'd6:  c = 7'h35;  6'd7:  c = 7'h36;  6'd8:  c = 7'h37;  6'd9:  c = 7'h38;
      6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2D;  6'd13: c = 7'h3D;
      6'd16: c = 7'h71;  6'd17: c = 7'h77;  6'd18: c = 7'h65;  6'd19: c = 7'h72;
      6'd20: c = 7'h74;  6'd21: c = 7'h79;  6'd22: c = 7'h75;  6'd23: c = 7'h69;
      6'd24: c = 7'h6F;  6'd25: c = 7'h70;  6'd26: c = 7'h5B;  6'd27: c = 7'h5D;
      6'd30: c = 7'h61;  6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;
      6'd34: c = 7'h67;  6'd35: c = 7'h68;  6'd36: c = 7'h6A;  6'd37: c = 7'h6B;
      6'd38: c = 7'h6C;  6'd39: c = 7'h3B;  6'd40: c = 7'h27;  6'd41: c = 7'h60;
      6'd43: c = 7'h5C;  6'd44: c = 7'h7A;  6'd45: c = 7'h78;  6'd46: c = 7'h63;
      6'd47: c = 7'h76;  6'd48: c = 7'h62;  6'd49: c = 7'h6E;  6'd50: c = 7'h6D;
      6'd51: c = 7'h2C;  6'd52: c = 7'h2E;  6'd53: c = 7'h2F;  6'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // shifted key table, shifted slash has no character
  function automatic logic [6:0] shift_char(input logic [5:0] code);
    logic [6:0] c;
    case (code)
      6'd2:  c = 7'h21;  6'd3:  c = 7'h40;  6'd4:  c = 7'h23;  6'd5:  c = 7'h24;
      6'd6:  c = 7'h25;  6'd7:  c = 7'h5E;  6'd8:  c = 7'h26;  6'd9:  c = 7'h2A;
      6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5F;  6'd13: c = 7'h2B;
      6'd16: c = 7'h51;  6'd17: c = 7'h57;  6'd18: c = 7'h45;  6'd19: c = 7'h52;
      6'd20: c = 7'h54;  6'd21: c = 7'h59;  6'd22: c = 7'h55;  6'd23: c = 7'h49;
      6'd24: c = 7'h4F;  6'd25: c = 7'h50;  6'd26: c = 7'h7B;  6'd27: c = 7'h7D;
      6'd30: c = 7'h41;  6'd31: c = 7'h53;  6'd32: c = 7'h44;  6'd33: c = 7'h46;
      6'd34: c = 7'h47;  6'd35: c = 7'h48;  6'd36: c = 7'h4A;  6'd37: c = 7'h4B;
      6'd38: c = 7'h4C;  6'd39: c = 7'h3A;  6'd40: c = 7'h22;  6'd41: c = 7'h7E;
      6'd43: c = 7'h7C;  6'd44: c = 7'h5A;  6'd45: c = 7'h58;  6'd46: c = 7'h43;
      6'd47: c = 7'h56;  6'd48: c = 7'h42;  6'd49: c = 7'h4E;  6'd50: c = 7'h4D;
      6'd51: c = 7'h3C;  6'd52: c = 7'h3E;  6'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/skd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module skd_in_stage
  import skd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_ready,
  input  wire skd_item_t item,
  output logic           hold_valid,
  output skd_item_t      hold_item,
  input  wire logic      hold_take
);

  // register refills in the same cycle its content moves on
  assign item_ready = !hold_valid || hold_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      hold_item <= item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/skd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module skd_decode
  import skd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      fire,
  input  wire skd_item_t item,
  output skd_result_t    result
);

  logic prefix_pending, prefix_pending_next;
  logic shift_flag, shift_flag_next;
  logic caps_flag, caps_flag_next;
  logic lock_flag, lock_flag_next;

  skd_event_t ev;
  logic [6:0] ch;
  logic [6:0] key_char;
  logic [7:0] code;

  assign code = item.scan_byte;

  // table lookup for plain character keys
  always_comb begin
    if (shift_flag) begin
      key_char = shift_char(code[5:0]);
    end else begin
      key_char = plain_char(code[5:0]);
      if (caps_flag && key_char >= 7'h61 && key_char <= 7'h7A) begin
        key_char = key_char - CASE_OFFSET;
      end
    end
  end

  always_comb begin
    ev                  = EV_NONE;
    ch                  = 7'd0;
    prefix_pending_next = prefix_pending;
    shift_flag_next     = shift_flag;
    caps_flag_next      = caps_flag;
    lock_flag_next      = lock_flag;
    if (item.command == CMD_LINE_TAKEN) begin
      lock_flag_next = 1'b0;
    end else if (code == SC_PREFIX) begin
      prefix_pending_next = 1'b1;
    end else if (prefix_pending) begin
      prefix_pending_next = 1'b0;
      if (!code[7] && !lock_flag) begin
        unique case (code)
          SC_EXT_UP:     ev = EV_UP;
          SC_EXT_DOWN:   ev = EV_DOWN;
          SC_EXT_LEFT:   ev = EV_LEFT;
          SC_EXT_RIGHT:  ev = EV_RIGHT;
          SC_EXT_DELETE: ev = EV_DELETE;
          SC_EXT_HOME:   ev = EV_HOME;
          SC_EXT_END:    ev = EV_END;
          default:       ev = EV_NONE;
        endcase
      end
    end else if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
      shift_flag_next = 1'b1;
    end else if (code == SC_LSHIFT_BRK || code == SC_RSHIFT_BRK) begin
      shift_flag_next = 1'b0;
    end else if (code == SC_CAPS) begin
      caps_flag_next = !caps_flag;
    end else if (code[7] || lock_flag || code > SC_CODE_LIMIT) begin
      ev = EV_NONE;
    end else if (code == SC_BACKSPACE) begin
      ev = EV_BACKSPACE;
    end else if (code == SC_ENTER) begin
      ev             = EV_ENTER;
      lock_flag_next = 1'b1;
    end else if (key_char != 7'd0) begin
      ev = EV_CHAR;
      ch = key_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pending <= 1'b0;
      shift_flag     <= 1'b0;
      caps_flag      <= 1'b0;
      lock_flag      <= 1'b0;
    end else if (fire) begin
      prefix_pending <= prefix_pending_next;
      shift_flag     <= shift_flag_next;
      caps_flag      <= caps_flag_next;
      lock_flag      <= lock_flag_next;
    end
  end

  always_comb begin
    result.event_kind  = ev;
    result.ascii_char  = ch;
    result.line_locked = lock_flag_next;
    result.shift_held  = shift_flag_next;
    result.caps_active = caps_flag_next;
  end

endmodule

`default_nettype wire

>>> rtl/core/skd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module skd_out_stage
  import skd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load_valid,
  output logic             load_ready,
  input  wire skd_result_t load_data,
  output logic             result_valid,
  input  wire logic        result_ready,
  output skd_result_t      result
);

  assign load_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_ready) begin
      result_valid <= load_valid;
    end
    if (load_valid && load_ready) begin
      result <= load_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/scancode_key_event_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// set-1 scancode to line-editing event decoder
//
// item channel (item_valid/item_ready/item): one transaction is either a
// scancode byte (command = scan) or a line-taken notice from software
// result channel (result_valid/result_ready/result): exactly one transaction
// per item, carrying the edit event, the ascii character for char events,
// and the line lock, shift and caps flags as they stand after that item
//
// path: an item goes into the input register, is decoded by one pass of
// combinational logic against the flag registers, and lands in the result
// register, from which it is offered on the result channel
// throughput: one item per cycle while result_ready is high, set by the
// single decode pass; both registers refill in the cycle they empty, so the
// input register still takes one more item while a result waits
//
// stall: when result_ready is low the result register holds, the input
// register fills and then item_ready drops until the result is taken
// reset: synchronous, clears both valid bits and all four flags (prefix,
// shift, caps, line lock); the block is ready as soon as reset is released
module scancode_key_event_decoder
  import skd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire skd_item_t   item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output skd_result_t      result
);

  logic        hold_valid;
  skd_item_t   hold_item;
  logic        load_ready;
  logic        fire;
  skd_result_t decoded;

  // held item is decoded and its flags committed when the result register takes it
  assign fire = hold_valid && load_ready;

  skd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .hold_take  (load_ready)
  );

  skd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (hold_item),
    .result (decoded)
  );

  skd_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (hold_valid),
    .load_ready   (load_ready),
    .load_data    (decoded),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> sim/scancode_key_event_decoder_tb.sv
`timescale 1ns / 1ps

module scancode_key_event_decoder_tb;
  import skd_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 150;
  localparam int PRINT_LIMIT  = 30;

  // plain keys used by the directed tests
  localparam logic [7:0] KEY_ONE   = 8'h02;
  localparam logic [7:0] KEY_A     = 8'h1E;
  localparam logic [7:0] KEY_SLASH = 8'h35;
  localparam logic [7:0] KEY_SPACE = 8'h39;
  localparam logic [7:0] KEY_F1    = 8'h3B;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  skd_item_t   item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  skd_result_t result;

  scancode_key_event_decoder uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // key tables indexed by scancode, '?' marks a key with no character
  // (the shifted slash is one of those)
  string plain_keys = "??1234567890-=??qwertyuiop[]??asdfghjkl;'`?\\zxcvbnm,./??? ";
  string shift_keys = "??!@#$%^&*()_+??QWERTYUIOP{}??ASDFGHJKL:\"~?|ZXCVBNM<>???? ";

  // decoder state as the testbench sees it
  logic prefix_q    = 1'b0;
  logic shift_q     = 1'b0;
  logic caps_q      = 1'b0;
  logic line_lock_q = 1'b0;

  // expected key events, oldest first
  skd_result_t expected_events[$];
  skd_result_t want;

  int mismatches = 0;
  int sent_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_request = 1'b0;
  int hold_left = 0;

  // works out the key event for one transaction and advances the state
  function automatic skd_result_t predict_key_event(input skd_item_t it);
    skd_result_t r;
    skd_event_t ev;
    logic [7:0] code;
    logic [7:0] ch;
    ev = EV_NONE;
    ch = 8'h00;
    code = it.scan_byte;
    if (it.command == CMD_LINE_TAKEN) begin
      // software took the line, the byte is ignored
      line_lock_q = 1'b0;
    end else if (code == SC_PREFIX) begin
      prefix_q = 1'b1;
    end else if (prefix_q) begin
      // byte after the prefix: cursor and edit keys only
      prefix_q = 1'b0;
      if (!code[7] && !line_lock_q) begin
        case (code)
          SC_EXT_UP:     ev = EV_UP;
          SC_EXT_DOWN:   ev = EV_DOWN;
          SC_EXT_LEFT:   ev = EV_LEFT;
          SC_EXT_RIGHT:  ev = EV_RIGHT;
          SC_EXT_DELETE: ev = EV_DELETE;
          SC_EXT_HOME:   ev = EV_HOME;
          SC_EXT_END:    ev = EV_END;
          default:       ev = EV_NONE;
        endcase
      end
    end else if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
      shift_q = 1'b1;
    end else if (code == SC_LSHIFT_BRK || code == SC_RSHIFT_BRK) begin
      shift_q = 1'b0;
    end else if (code == SC_CAPS) begin
      caps_q = !caps_q;
    end else if (code[7] || line_lock_q || code > SC_CODE_LIMIT) begin
      ev = EV_NONE;
    end else if (code == SC_BACKSPACE) begin
      ev = EV_BACKSPACE;
    end else if (code == SC_ENTER) begin
      ev = EV_ENTER;
      line_lock_q = 1'b1;
    end else begin
      // caps only uppercases letters, and only without shift
      ch = shift_q ? shift_keys[int'(code)] : plain_keys[int'(code)];
      if (!shift_q && caps_q && ch >= "a" && ch <= "z") ch = ch - 8'd32;
      if (ch == "?") ch = 8'h00;
      else ev = EV_CHAR;
    end
    r.event_kind  = ev;
    r.ascii_char  = ch[6:0];
    r.line_locked = line_lock_q;
    r.shift_held  = shift_q;
    r.caps_active = caps_q;
    return r;
  endfunction

  // offer one transaction, return at the edge where it is taken
  task automatic send_item(input skd_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected_events.push_back(predict_key_event(it));
    sent_count++;
  endtask

  task automatic send_scan(input logic [7:0] code);
    send_item({CMD_SCAN, code});
  endtask

  task automatic send_line_taken(input logic [7:0] junk);
    send_item({CMD_LINE_TAKEN, junk});
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("%0t ns: %s expected %0h got %0h", $time, name, exp_val, got_val);
    end
  endtask

  // result side: every taken result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
          $display("%0t ns: result %h with nothing expected, expected none",
                   $time, result);
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", want.event_kind, result.event_kind);
        check_field("ascii_char", want.ascii_char, result.ascii_char);
        check_field("line_locked", want.line_locked, result.line_locked);
        check_field("shift_held", want.shift_held, result.shift_held);
        check_field("caps_active", want.caps_active, result.caps_active);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // table lookups: extremes, shift, caps, their mix, shifted slash
  task automatic test_plain_and_shifted_keys();
    send_scan(8'h00);
    send_scan(8'hFF);
    send_scan(KEY_F1);        // a code past the table
    send_scan(KEY_SPACE);     // last code in the table
    send_scan(KEY_A);
    send_scan(SC_CAPS);
    send_scan(KEY_A);         // caps uppercases letters
    send_scan(KEY_ONE);       // but not digits
    send_scan(SC_RSHIFT_MAKE);
    send_scan(KEY_A);         // shift wins over caps
    send_scan(KEY_SLASH);     // shifted slash has no character
    send_scan(SC_RSHIFT_BRK);
    send_scan(SC_CAPS);
    send_scan(SC_BACKSPACE);
  endtask

  // enter locks the line, only shift, caps and the prefix act until it is taken
  task automatic test_line_lock();
    send_scan(SC_ENTER);
    send_scan(KEY_A);
    send_scan(SC_LSHIFT_MAKE);
    send_scan(SC_CAPS);
    send_scan(SC_PREFIX);
    send_scan(SC_EXT_UP);
    send_line_taken(8'hFF);
    send_scan(SC_LSHIFT_BRK);
    send_scan(SC_CAPS);
  endtask

  // repeated prefix, extended break, shift code after a prefix
  task automatic test_extended_prefix();
    send_scan(SC_PREFIX);
    send_scan(SC_PREFIX);
    send_scan(SC_EXT_UP);
    send_scan(SC_PREFIX);
    send_scan(SC_EXT_UP | 8'h80);
    send_scan(SC_PREFIX);
    send_scan(SC_RSHIFT_MAKE);
  endtask

  // mostly typing-like sequences, some noise
  task automatic test_random_typing(input int count);
    int pick;
    int stop_at;
    logic [7:0] code;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      pick = $urandom_range(99);
      if (line_lock_q && pick < 40) begin
        send_line_taken(8'($urandom_range(255)));
      end else if (pick < 40) begin
        send_scan(8'($urandom_range(57)));
      end else if (pick < 55) begin
        case ($urandom_range(8))
          0: code = SC_EXT_UP;
          1: code = SC_EXT_DOWN;
          2: code = SC_EXT_LEFT;
          3: code = SC_EXT_RIGHT;
          4: code = SC_EXT_DELETE;
          5: code = SC_EXT_HOME;
          6: code = SC_EXT_END;
          7: code = {1'b1, 7'($urandom_range(127))};
          default: code = 8'($urandom_range(255));
        endcase
        send_scan(SC_PREFIX);
        send_scan(code);
      end else if (pick < 63) begin
        case ($urandom_range(3))
          0: send_scan(SC_LSHIFT_MAKE);
          1: send_scan(SC_RSHIFT_MAKE);
          2: send_scan(SC_LSHIFT_BRK);
          default: send_scan(SC_RSHIFT_BRK);
        endcase
      end else if (pick < 67) begin
        send_scan(SC_CAPS);
      end else if (pick < 73) begin
        send_scan(SC_ENTER);
      end else if (pick < 78) begin
        send_scan(SC_BACKSPACE);
      end else if (pick < 84) begin
        send_line_taken(8'($urandom_range(255)));
      end else begin
        send_item(9'($urandom_range(511)));
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_receiver_hold();
    hold_request = 1'b1;
    test_random_typing(40);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender seldom idle, receiver mostly stalled
    send_idle_pct = 16;
    recv_idle_pct = 83;
    test_plain_and_shifted_keys();
    test_line_lock();
    test_extended_prefix();
    test_random_typing(195);

    // sender mostly idle, receiver seldom stalled
    send_idle_pct = 83;
    recv_idle_pct = 16;
    test_random_typing(195);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_typing(195);
    test_receiver_hold();

    item_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/skd_pkg.sv
rtl/core/skd_in_stage.sv
rtl/core/skd_decode.sv
rtl/core/skd_out_stage.sv
rtl/core/scancode_key_event_decoder.sv
sim/scancode_key_event_decoder_tb.sv
